[sv/ihm_pkg.sv]
// Shared types and constants for the integer key hash map.
// No dependencies; imported by every module of the block.
package ihm_pkg;

   localparam int MAX_BUCKETS_DEF    = 256;
   localparam int ENTRY_CAPACITY_DEF = 256;
   localparam int KEY_W              = 32;
   localparam int VALUE_W            = 32;
   localparam int CSR_W              = 9;
   localparam int COUNT_OUT_W        = 9;
   localparam int BITS_PER_STEP      = 4;
   localparam int DIV_STEPS          = KEY_W / BITS_PER_STEP;
   localparam logic [CSR_W-1:0] BUCKET_COUNT_RESET = 9'd256;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_HEAD,
      BK_LINK,
      BK_CMP
   } back_state_type;

   typedef struct packed {
      op_type               op;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
   } req_item_type;

endpackage

[sv/ihm_front.sv]
// Front end: takes a request and computes its bucket (key modulo bucket count),
// four quotient bits per cycle. Depends on ihm_pkg.
module ihm_front
   import ihm_pkg::*;
#(
   parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         load,
   input  req_item_type                                 item,
   input  logic [$clog2(MAX_BUCKETS+1)-1:0]             divisor,
   output logic                                         busy,
   output logic                                         push,
   output req_item_type                                 push_item,
   output logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] push_bucket
);
   localparam int NW = $clog2(MAX_BUCKETS+1);
   localparam int RW = NW + 1;
   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int SCW = $clog2(DIV_STEPS);

   logic               busy_ff, busy_in;
   logic               push_ff, push_in;
   logic [SCW-1:0]     step_ff, step_in;
   logic [RW-1:0]      rem_ff, rem_in;
   logic [KEY_W-1:0]   sh_ff, sh_in;
   logic [NW-1:0]      div_ff, div_in;
   req_item_type       item_ff, item_in;

   always_comb begin
      logic [RW-1:0]    r;
      logic [KEY_W-1:0] s;
      r = rem_ff;
      s = sh_ff;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         r = {r[RW-2:0], s[KEY_W-1]};
         s = {s[KEY_W-2:0], 1'b0};
         if (r >= RW'(div_ff)) begin
            r = r - RW'(div_ff);
         end
      end
      busy_in = busy_ff;
      push_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      div_in  = div_ff;
      item_in = item_ff;
      if (load) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         sh_in   = item.key;
         div_in  = divisor;
         item_in = item;
      end else if (busy_ff) begin
         rem_in  = r;
         sh_in   = s;
         step_in = step_ff + 1'b1;
         if (step_ff == SCW'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            push_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         push_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         push_ff <= push_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      div_ff  <= div_in;
      item_ff <= item_in;
   end

   assign busy        = busy_ff;
   assign push        = push_ff;
   assign push_item   = item_ff;
   assign push_bucket = BW'(rem_ff);

endmodule

[sv/ihm_queue.sv]
// Two-entry queue between the front end and the back end.
// Depends on ihm_pkg only for the default WIDTH, KEY_W.
module ihm_queue
   import ihm_pkg::*;
#(
   parameter int WIDTH = KEY_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] slot_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             rd_ff, rd_in, wr_ff, wr_in;

   always_comb begin
      count_in = count_ff;
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      if (push) begin
         wr_in = ~wr_ff;
      end
      if (pop && count_ff != 2'd0) begin
         rd_in = ~rd_ff;
      end
      case ({push, pop && count_ff != 2'd0})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ff];

endmodule

[sv/ihm_back.sv]
// Back end: walks a bucket chain in the entry memories and applies add,
// remove, lookup or clear. Depends on ihm_pkg.
module ihm_back
   import ihm_pkg::*;
#(
   parameter int MAX_BUCKETS    = MAX_BUCKETS_DEF,
   parameter int ENTRY_CAPACITY = ENTRY_CAPACITY_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  req_item_type         q_item,
   input  logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] q_bucket,
   output logic                 q_pop,
   output logic                 busy,
   output logic                 rsp_valid,
   output status_type           rsp_status,
   output logic [VALUE_W-1:0]   rsp_found_value,
   output logic [COUNT_OUT_W-1:0] rsp_item_count
);
   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int SW = (ENTRY_CAPACITY > 1) ? $clog2(ENTRY_CAPACITY) : 1;
   localparam int EW = $clog2(ENTRY_CAPACITY + 1);
   localparam logic [EW-1:0] EMPTY = EW'(ENTRY_CAPACITY);

   logic [KEY_W-1:0]   key_mem   [ENTRY_CAPACITY];
   logic [VALUE_W-1:0] value_mem [ENTRY_CAPACITY];
   logic [EW-1:0]      next_mem  [ENTRY_CAPACITY];
   logic [EW-1:0]      head_mem  [MAX_BUCKETS];

   back_state_type state_ff, state_in;
   req_item_type   item_ff, item_in;
   logic [BW-1:0]  bucket_ff, bucket_in;
   logic [EW-1:0]  cur_ff, cur_in, prev_ff, prev_in, head_ff, head_in;
   logic [EW-1:0]  count_ff, count_in;
   logic [ENTRY_CAPACITY-1:0] used_ff, used_in;
   logic [MAX_BUCKETS-1:0]    hvalid_ff, hvalid_in;
   logic [SW-1:0]  free_ff, free_in;
   logic           free_any_ff, free_any_in;

   logic [KEY_W-1:0]   key_rd_ff;
   logic [VALUE_W-1:0] value_rd_ff;
   logic [EW-1:0]      next_rd_ff, head_rd_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_found_ff, rsp_found_in;

   logic               entry_we, next_we, head_we;
   logic [SW-1:0]      entry_wa, next_wa;
   logic [EW-1:0]      next_wd, head_wd;
   logic [BW-1:0]      head_ra;

   // lowest free pool slot, registered; used bits settle long before use
   always_comb begin
      free_in     = '0;
      free_any_in = 1'b0;
      for (int i = ENTRY_CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_in     = SW'(i);
            free_any_in = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (q_valid && q_item.op != OP_CLEAR) state_in = BK_HEAD;
         BK_HEAD: state_in = BK_LINK;
         BK_LINK: state_in = (cur_ff == EMPTY) ? BK_IDLE : BK_CMP;
         BK_CMP:  state_in = (key_rd_ff == item_ff.key) ? BK_IDLE : BK_LINK;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      item_in       = item_ff;
      bucket_in     = bucket_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      hvalid_in     = hvalid_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_found_in  = '0;
      entry_we      = 1'b0;
      next_we       = 1'b0;
      head_we       = 1'b0;
      entry_wa      = free_ff;
      next_wa       = free_ff;
      next_wd       = head_ff;
      head_wd       = EW'(free_ff);
      head_ra       = q_bucket;
      q_pop         = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               item_in   = q_item;
               bucket_in = q_bucket;
               if (q_item.op == OP_CLEAR) begin
                  used_in      = '0;
                  hvalid_in    = '0;
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         BK_HEAD: begin
            head_in = hvalid_ff[bucket_ff] ? head_rd_ff : EMPTY;
            cur_in  = hvalid_ff[bucket_ff] ? head_rd_ff : EMPTY;
            prev_in = EMPTY;
         end
         BK_LINK: begin
            if (cur_ff == EMPTY) begin
               // key absent
               rsp_valid_in = 1'b1;
               if (item_ff.op == OP_ADD) begin
                  if (free_any_ff) begin
                     entry_we             = 1'b1;
                     next_we              = 1'b1;
                     head_we              = 1'b1;
                     hvalid_in[bucket_ff] = 1'b1;
                     used_in[free_ff]     = 1'b1;
                     count_in             = count_ff + 1'b1;
                  end else begin
                     rsp_status_in = ST_FULL;
                  end
               end else begin
                  rsp_status_in = ST_MISS;
               end
            end
         end
         BK_CMP: begin
            if (key_rd_ff == item_ff.key) begin
               rsp_valid_in = 1'b1;
               case (item_ff.op)
                  OP_ADD:    rsp_status_in = ST_MISS;
                  OP_REMOVE: begin
                     // unlink: predecessor or bucket head takes our successor
                     if (prev_ff == EMPTY) begin
                        head_we = 1'b1;
                        head_wd = next_rd_ff;
                     end else begin
                        next_we = 1'b1;
                        next_wa = prev_ff[SW-1:0];
                        next_wd = next_rd_ff;
                     end
                     used_in[cur_ff[SW-1:0]] = 1'b0;
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_LOOKUP: rsp_found_in = value_rd_ff;
                  default:   rsp_status_in = ST_OK;
               endcase
            end else begin
               prev_in = cur_ff;
               cur_in  = next_rd_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         hvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         hvalid_ff    <= hvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      bucket_ff     <= bucket_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      head_ff       <= head_in;
      free_ff       <= free_in;
      free_any_ff   <= free_any_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         key_mem[entry_wa]   <= item_ff.key;
         value_mem[entry_wa] <= item_ff.value;
      end
      key_rd_ff   <= key_mem[cur_ff[SW-1:0]];
      value_rd_ff <= value_mem[cur_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      next_rd_ff <= next_mem[cur_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[bucket_ff] <= head_wd;
      end
      head_rd_ff <= head_mem[head_ra];
   end

   assign busy            = (state_ff != BK_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_item_count  = COUNT_OUT_W'(32'(count_ff));

endmodule

[sv/integer_key_hash_map_core.sv]
// Integer key hash map: chained buckets over a fixed entry pool.
// Path from accept to result beat: bucket modulo in the front end, push into the queue, pop by
// the back end, a read of the bucket head, then a link step and a compare step per chain link
// visited; a miss ends on a link step that finds the chain end, and a clear is answered from the
// pop. Throughput: one request at a time; busy drops in the result cycle.
// Reset: synchronous, clears every bucket and slot, count to 0, bucket count 256.
module integer_key_hash_map_core
   import ihm_pkg::*;
#(
   parameter int MAX_BUCKETS    = MAX_BUCKETS_DEF,
   parameter int ENTRY_CAPACITY = ENTRY_CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_operation,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic [VALUE_W-1:0]      req_value,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [VALUE_W-1:0]      rsp_found_value,
   output logic [COUNT_OUT_W-1:0]  rsp_item_count,
   input  logic                    csr_write_enable,
   input  logic [CSR_W-1:0]        csr_write_data
);
   localparam int NW = $clog2(MAX_BUCKETS + 1);
   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int QW = $bits(req_item_type) + BW;

   logic [CSR_W-1:0] bucket_count_ff, bucket_count_in;
   logic [NW-1:0]    divisor;
   logic             accept;
   req_item_type     req_item;
   logic             front_busy, push, back_busy, q_valid, q_pop;
   req_item_type     push_item, q_item;
   logic [BW-1:0]    push_bucket, q_bucket;
   status_type       status;

   // hold the bucket count register; write straight through, no read-back
   assign bucket_count_in = csr_write_enable ? csr_write_data : bucket_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_COUNT_RESET;
      end else begin
         bucket_count_ff <= bucket_count_in;
      end
   end

   // zero acts as one bucket, anything above the table size saturates
   always_comb begin
      if (bucket_count_ff == '0) begin
         divisor = NW'(1);
      end else if (32'(bucket_count_ff) > 32'(MAX_BUCKETS)) begin
         divisor = NW'(MAX_BUCKETS);
      end else begin
         divisor = NW'(32'(bucket_count_ff));
      end
   end

   assign accept         = start && !busy;
   assign req_item.op    = op_type'(req_operation);
   assign req_item.key   = req_key;
   assign req_item.value = req_value;

   ihm_front #(
      .MAX_BUCKETS(MAX_BUCKETS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .item       (req_item),
      .divisor    (divisor),
      .busy       (front_busy),
      .push       (push),
      .push_item  (push_item),
      .push_bucket(push_bucket)
   );

   ihm_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_bucket, push_item}),
      .pop      (q_pop),
      .not_empty(q_valid),
      .pop_data ({q_bucket, q_item})
   );

   ihm_back #(
      .MAX_BUCKETS   (MAX_BUCKETS),
      .ENTRY_CAPACITY(ENTRY_CAPACITY)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_bucket       (q_bucket),
      .q_pop          (q_pop),
      .busy           (back_busy),
      .rsp_valid      (rsp_valid),
      .rsp_status     (status),
      .rsp_found_value(rsp_found_value),
      .rsp_item_count (rsp_item_count)
   );

   assign rsp_status = status;

   // one request in flight anywhere in the chain of front, queue and back
   assign busy = front_busy || push || q_valid || back_busy;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("busy not raised after accept");

   a_rsp_follows_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result beat without a request");

   a_found_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found_value == '0 || status == ST_OK))
      else $error("found value on a failed request");

endmodule

[dv/tb.sv]
// Self-checking testbench for integer_key_hash_map_core.
// Depends on ihm_pkg and the core RTL; it predicts every beat with its own map model.
module tb;
   import ihm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type          status;
      logic [VALUE_W-1:0]  found;
      logic [COUNT_OUT_W-1:0] count;
   } map_answer_type;

   localparam int NIL = ENTRY_CAPACITY_DEF;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [1:0]              req_operation = '0;
   logic signed [KEY_W-1:0] req_key = '0;
   logic [VALUE_W-1:0]      req_value = '0;
   logic                    rsp_valid;
   logic [1:0]              rsp_status;
   logic [VALUE_W-1:0]      rsp_found_value;
   logic [COUNT_OUT_W-1:0]  rsp_item_count;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_W-1:0]        csr_write_data = '0;

   integer_key_hash_map_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_item_count  (rsp_item_count),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Shadow copy of the map: entry pool, chain links and bucket heads.
   logic [KEY_W-1:0]   shadow_key  [ENTRY_CAPACITY_DEF];
   logic [VALUE_W-1:0] shadow_value[ENTRY_CAPACITY_DEF];
   int                 shadow_next [ENTRY_CAPACITY_DEF];
   bit                 shadow_used [ENTRY_CAPACITY_DEF];
   int                 shadow_head [MAX_BUCKETS_DEF];
   int                 shadow_total;
   logic [CSR_W-1:0]   shadow_buckets;

   req_item_type   pending_reqs[$];
   map_answer_type expected_answers[$];
   logic [KEY_W-1:0] key_pool[$];
   int fail_count = 0;
   int gap_left   = 0;
   int burst_left = 1;

   function automatic void wipe_map();
      for (int i = 0; i < ENTRY_CAPACITY_DEF; i++) shadow_used[i] = 1'b0;
      for (int b = 0; b < MAX_BUCKETS_DEF; b++) shadow_head[b] = NIL;
      shadow_total = 0;
   endfunction

   // Walk one chain; slot is NIL on a miss, prev is NIL when the hit is the head.
   function automatic void find_in_chain(input int b, input logic [KEY_W-1:0] k,
                                         output int slot, output int prev);
      int cur;
      int steps;
      cur = shadow_head[b];
      prev = NIL;
      steps = 0;
      slot = NIL;
      while (cur < NIL && steps < ENTRY_CAPACITY_DEF) begin
         if (shadow_key[cur] == k) begin
            slot = cur;
            return;
         end
         prev = cur;
         cur = shadow_next[cur];
         steps++;
      end
      prev = NIL;
   endfunction

   // Apply one request to the shadow map and queue the answer it must give.
   function automatic void apply_map_request(input req_item_type it);
      map_answer_type ans;
      int n;
      int b;
      int slot;
      int prev;
      n = shadow_buckets;
      if (n == 0) n = 1;
      if (n > MAX_BUCKETS_DEF) n = MAX_BUCKETS_DEF;
      b = int'(it.key % n);
      ans.status = ST_OK;
      ans.found = '0;
      case (it.op)
         OP_CLEAR: begin
            wipe_map();
         end
         OP_ADD: begin
            find_in_chain(b, it.key, slot, prev);
            if (slot < NIL) begin
               ans.status = ST_MISS;
            end else begin
               slot = NIL;
               for (int i = 0; i < ENTRY_CAPACITY_DEF; i++)
                  if (!shadow_used[i] && slot == NIL) slot = i;
               if (slot == NIL) begin
                  ans.status = ST_FULL;
               end else begin
                  shadow_used[slot] = 1'b1;
                  shadow_key[slot] = it.key;
                  shadow_value[slot] = it.value;
                  shadow_next[slot] = shadow_head[b];
                  shadow_head[b] = slot;
                  shadow_total++;
               end
            end
         end
         OP_REMOVE: begin
            find_in_chain(b, it.key, slot, prev);
            if (slot == NIL) begin
               ans.status = ST_MISS;
            end else begin
               if (prev < NIL) shadow_next[prev] = shadow_next[slot];
               else shadow_head[b] = shadow_next[slot];
               shadow_used[slot] = 1'b0;
               if (shadow_total > 0) shadow_total--;
            end
         end
         default: begin
            find_in_chain(b, it.key, slot, prev);
            if (slot == NIL) ans.status = ST_MISS;
            else ans.found = shadow_value[slot];
         end
      endcase
      ans.count = shadow_total[COUNT_OUT_W-1:0];
      expected_answers.push_back(ans);
   endfunction

   // Driver: present queued beats in bursts, with random gaps between bursts.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            apply_map_request('{op_type'(req_operation), req_key, req_value});
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_item_type nxt;
               nxt = pending_reqs.pop_front();
               req_operation <= nxt.op;
               req_key <= nxt.key;
               req_value <= nxt.value;
               start <= 1'b1;
               if (burst_left <= 1) begin
                  // about half the bursts run back to back with no gap at all
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each result beat lives for one cycle; compare it with the oldest answer.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            $error("result beat with nothing expected: status %0d", rsp_status);
            fail_count++;
         end else begin
            map_answer_type exp_ans;
            exp_ans = expected_answers.pop_front();
            if (rsp_status !== exp_ans.status) begin
               $error("status: expected %0d, actual %0d", exp_ans.status, rsp_status);
               fail_count++;
            end
            if (rsp_found_value !== exp_ans.found) begin
               $error("found_value: expected %h, actual %h", exp_ans.found,
                      rsp_found_value);
               fail_count++;
            end
            if (rsp_item_count !== exp_ans.count) begin
               $error("item_count: expected %0d, actual %0d", exp_ans.count,
                      rsp_item_count);
               fail_count++;
            end
         end
      end
   end

   task automatic queue_req(input op_type op, input logic [KEY_W-1:0] k,
                            input logic [VALUE_W-1:0] v);
      pending_reqs.push_back('{op, k, v});
   endtask

   // Hold until every beat went out and came back, then let the core settle.
   task automatic drain();
      while (pending_reqs.size() > 0 || start || expected_answers.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_buckets(input logic [CSR_W-1:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_buckets = v;
   endtask

   // Mostly reuse recent keys so adds collide and lookups hit; drop old ones.
   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      if (key_pool.size() < 4 || $urandom_range(0, 9) < 3) begin
         case ($urandom_range(0, 2))
            0: k = $urandom();
            1: k = $urandom_range(0, 600);
            default: k = -$urandom_range(1, 300);
         endcase
         key_pool.push_back(k);
         if (key_pool.size() > 40) void'(key_pool.pop_front());
      end else begin
         k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      return k;
   endfunction

   task automatic queue_random(input int count);
      int r;
      op_type op;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 42) op = OP_ADD;
         else if (r < 64) op = OP_REMOVE;
         else if (r < 99) op = OP_LOOKUP;
         else op = OP_CLEAR;
         queue_req(op, pick_key(), $urandom());
      end
   endtask

   initial begin
      logic [CSR_W-1:0] settings[$];
      wipe_map();
      shadow_buckets = BUCKET_COUNT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: key and value extremes, every operation, a middle-of-chain removal.
      queue_req(OP_ADD, 32'h0000_0000, 32'h0000_0000);
      queue_req(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(OP_ADD, 32'h8000_0000, 32'hA5A5_5A5A);
      queue_req(OP_ADD, 32'h7FFF_FFFF, 32'h5A5A_A5A5);
      queue_req(OP_ADD, 32'h0000_0000, 32'h1234_5678);
      queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      queue_req(OP_LOOKUP, 32'h8000_0000, 32'h0);
      queue_req(OP_LOOKUP, 32'h0000_0001, 32'h0);
      queue_req(OP_ADD, 32'd256, 32'd2);
      queue_req(OP_ADD, 32'd512, 32'd3);
      queue_req(OP_REMOVE, 32'd256, 32'h0);
      queue_req(OP_LOOKUP, 32'd0, 32'h0);
      queue_req(OP_LOOKUP, 32'd512, 32'h0);
      queue_req(OP_LOOKUP, 32'd256, 32'h0);
      queue_req(OP_REMOVE, 32'd256, 32'h0);
      queue_req(OP_REMOVE, 32'd512, 32'h0);
      queue_req(OP_REMOVE, 32'd0, 32'h0);
      queue_req(OP_CLEAR, 32'h0, 32'h0);
      queue_req(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0);
      queue_req(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
      drain();

      // Fill the pool past capacity to reach the full status, then free a few slots.
      write_buckets(9'd256);
      for (int i = 0; i < 262; i++) queue_req(OP_ADD, 32'd1000 + 3 * i, $urandom());
      for (int i = 0; i < 10; i++) queue_req(OP_LOOKUP, 32'd1000 + 27 * i, 32'h0);
      for (int i = 0; i < 8; i++) queue_req(OP_REMOVE, 32'd1003 + 60 * i, 32'h0);
      for (int i = 0; i < 10; i++) queue_req(OP_ADD, $urandom(), $urandom());
      queue_req(OP_CLEAR, 32'h0, 32'h0);
      drain();

      // Sweep bucket counts, extremes included; entries survive across the changes.
      settings = '{9'd0, 9'd1, 9'd511, 9'd256, 9'd7, 9'd255, 9'd257, 9'd2};
      settings.push_back($urandom_range(3, 511));
      foreach (settings[s]) begin
         write_buckets(settings[s]);
         queue_random(125);
         drain();
      end

      if (fail_count == 0)
         $display("PASS integer_key_hash_map_core");
      else
         $display("FAIL integer_key_hash_map_core");
      $finish;
   end

   initial begin
      #50ms;
      $display("FAIL integer_key_hash_map_core");
      $finish;
   end

endmodule

[files.f]
sv/ihm_pkg.sv
sv/ihm_front.sv
sv/ihm_queue.sv
sv/ihm_back.sv
sv/integer_key_hash_map_core.sv
dv/tb.sv
